>>> hdl/mkp_pkg.sv
// ----------------------------------------------------------------------------
// Keypad scanner package
// Types, constants and the line decoder shared by the keypad scanner files.
// ----------------------------------------------------------------------------
`default_nettype none

package mkp_pkg;

  localparam int LINE_W = 4;
  localparam int CODE_W = 6;
  localparam int KEY_W  = 5;
  localparam int TICK_W = 8;

  localparam logic [LINE_W-1:0] LINES_IDLE       = 4'hF;
  localparam logic [KEY_W-1:0]  KEY_BASE         = 5'd4;
  localparam logic [CODE_W-1:0] LONG_OFFSET      = 6'd20;
  localparam logic [TICK_W-1:0] LONG_TICKS_RESET = 8'd150;

  localparam logic [LINE_W-1:0] LINE_CODE_0 = 4'h7;
  localparam logic [LINE_W-1:0] LINE_CODE_1 = 4'hB;
  localparam logic [LINE_W-1:0] LINE_CODE_2 = 4'hD;
  localparam logic [LINE_W-1:0] LINE_CODE_3 = 4'hE;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DEBOUNCE,
    PH_HELD,
    PH_LONG_HELD
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] idx;
  } line_dec_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
  } result_t;

  // Maps an active-low one-hot nibble to its line index.
  function automatic line_dec_t line_index(input logic [LINE_W-1:0] nib);
    line_dec_t d;
    d = '0;
    unique case (nib)
      LINE_CODE_0: d = '{ok: 1'b1, idx: 2'd0};
      LINE_CODE_1: d = '{ok: 1'b1, idx: 2'd1};
      LINE_CODE_2: d = '{ok: 1'b1, idx: 2'd2};
      LINE_CODE_3: d = '{ok: 1'b1, idx: 2'd3};
      default:     d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mkp_scan_if.sv
// ----------------------------------------------------------------------------
// Keypad scan channel
// Carries one scan tick of row and column sense lines with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkp_scan_if;
  logic                        valid;
  logic                        ready;
  logic [mkp_pkg::LINE_W-1:0]  row_lines;
  logic [mkp_pkg::LINE_W-1:0]  col_lines;

  modport source (output valid, output row_lines, output col_lines, input ready);
  modport sink (input valid, input row_lines, input col_lines, output ready);
endinterface

`default_nettype wire

>>> hdl/mkp_key_if.sv
// ----------------------------------------------------------------------------
// Keypad key event channel
// Carries one result item per scan tick with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkp_key_if;
  logic                        valid;
  logic                        ready;
  logic                        key_valid;
  logic [mkp_pkg::CODE_W-1:0]  key_code;

  modport source (output valid, output key_valid, output key_code, input ready);
  modport sink (input valid, input key_valid, input key_code, output ready);
endinterface

`default_nettype wire

>>> hdl/mkp_fsm.sv
// ----------------------------------------------------------------------------
// Keypad press state machine
// Debounces, decodes and times a key press, and reports the key on release.
// ----------------------------------------------------------------------------
`default_nettype none

module mkp_fsm (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [mkp_pkg::LINE_W-1:0]  row_lines,
  input  wire logic [mkp_pkg::LINE_W-1:0]  col_lines,
  input  wire logic [mkp_pkg::TICK_W-1:0]  long_press_ticks,
  output mkp_pkg::result_t                 result
);

  mkp_pkg::phase_t              phase, phase_next;
  logic [mkp_pkg::TICK_W-1:0]   hold_count, hold_count_next;
  logic [mkp_pkg::KEY_W-1:0]    latched_key, latched_key_next;

  logic                         down;
  logic [mkp_pkg::TICK_W-1:0]   count_inc;
  mkp_pkg::line_dec_t           row_dec;
  mkp_pkg::line_dec_t           col_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= mkp_pkg::PH_IDLE;
      hold_count  <= '0;
      latched_key <= '0;
    end else if (step) begin
      phase       <= phase_next;
      hold_count  <= hold_count_next;
      latched_key <= latched_key_next;
    end
  end

  always_comb begin
    down             = (row_lines != mkp_pkg::LINES_IDLE);
    row_dec          = mkp_pkg::line_index(row_lines);
    col_dec          = mkp_pkg::line_index(col_lines);
    count_inc        = hold_count + 8'd1;
    phase_next       = phase;
    hold_count_next  = hold_count;
    latched_key_next = latched_key;
    result           = '0;
    unique case (phase)
      mkp_pkg::PH_IDLE: begin
        if (down) begin
          phase_next = mkp_pkg::PH_DEBOUNCE;
        end
      end
      mkp_pkg::PH_DEBOUNCE: begin
        if (!down || !row_dec.ok || !col_dec.ok) begin
          phase_next = mkp_pkg::PH_IDLE;
        end else begin
          latched_key_next = mkp_pkg::KEY_BASE + {1'b0, col_dec.idx, 2'b00}
                             + {3'b000, row_dec.idx};
          phase_next       = mkp_pkg::PH_HELD;
        end
      end
      mkp_pkg::PH_HELD: begin
        if (down) begin
          if (count_inc >= long_press_ticks) begin
            hold_count_next = '0;
            phase_next      = mkp_pkg::PH_LONG_HELD;
          end else begin
            hold_count_next = count_inc;
          end
        end else begin
          hold_count_next  = '0;
          result.key_valid = 1'b1;
          result.key_code  = {1'b0, latched_key};
          latched_key_next = '0;
          phase_next       = mkp_pkg::PH_IDLE;
        end
      end
      mkp_pkg::PH_LONG_HELD: begin
        if (!down) begin
          result.key_valid = 1'b1;
          result.key_code  = {1'b0, latched_key} + mkp_pkg::LONG_OFFSET;
          latched_key_next = '0;
          phase_next       = mkp_pkg::PH_IDLE;
        end
      end
    endcase
  end

  a_event_on_release: assert property (@(posedge clk) disable iff (rst)
    result.key_valid |-> (phase == mkp_pkg::PH_HELD || phase == mkp_pkg::PH_LONG_HELD))
    else $error("key event outside a held phase");

  a_code_zero_when_quiet: assert property (@(posedge clk) disable iff (rst)
    !result.key_valid |-> (result.key_code == '0))
    else $error("key code not zero without an event");

  a_count_only_when_held: assert property (@(posedge clk) disable iff (rst)
    (phase != mkp_pkg::PH_HELD) |-> (hold_count == '0))
    else $error("hold counter running outside the held phase");

  a_long_hold_waits: assert property (@(posedge clk) disable iff (rst)
    (step && phase == mkp_pkg::PH_LONG_HELD && down) |=> (phase == mkp_pkg::PH_LONG_HELD))
    else $error("long hold left while the key is down");

endmodule

`default_nettype wire

>>> hdl/matrix_keypad_long_press_scanner.sv
// ----------------------------------------------------------------------------
// Matrix keypad long-press scanner
// Takes one scan tick of a 4x4 key matrix per item and returns one result item
// per tick. A press seen on two ticks in a row is decoded to key number
// 4 + 4*column + row and reported on release; a key held for long_press_ticks
// ticks is reported on release as key number + 20. Items pass through an input
// register and a result register with the state update between them, so one
// item is taken every cycle while the output side keeps up. long_press_ticks
// resets to 150 and must be written only while idle; the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_keypad_long_press_scanner (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [mkp_pkg::TICK_W-1:0]  cfg_wr_data,
  mkp_scan_if.sink                         scan_in,
  mkp_key_if.source                        key_out
);

  logic [mkp_pkg::TICK_W-1:0]  long_press_ticks;
  logic                        s1_valid;
  logic [mkp_pkg::LINE_W-1:0]  s1_rows;
  logic [mkp_pkg::LINE_W-1:0]  s1_cols;
  logic                        out_valid;
  logic                        out_free;
  logic                        advance;
  mkp_pkg::result_t            result;
  mkp_pkg::result_t            out_result;

  assign out_free      = !out_valid || key_out.ready;
  assign advance       = s1_valid && out_free;
  assign scan_in.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= mkp_pkg::LONG_TICKS_RESET;
    end else if (cfg_wr_en) begin
      long_press_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_in.ready) begin
      s1_valid <= scan_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) begin
      s1_rows <= scan_in.row_lines;
      s1_cols <= scan_in.col_lines;
    end
  end

  mkp_fsm u_fsm (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .row_lines        (s1_rows),
    .col_lines        (s1_cols),
    .long_press_ticks (long_press_ticks),
    .result           (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign key_out.valid     = out_valid;
  assign key_out.key_valid = out_result.key_valid;
  assign key_out.key_code  = out_result.key_code;

endmodule

`default_nettype wire

>>> tb/sv/matrix_keypad_long_press_scanner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Matrix keypad long-press scanner testbench
// Drives scan ticks with random gaps on both channels. It starts with a
// directed table of presses, releases and bad codes, then runs random phases
// under several long-press settings. Every result item is checked against the
// table's fixed value or a cycle-free model of the scanner state in the bench.
// ----------------------------------------------------------------------------

module matrix_keypad_long_press_scanner_tb;

  localparam logic [mkp_pkg::LINE_W-1:0] LINE_CODES [4] = '{
    mkp_pkg::LINE_CODE_0, mkp_pkg::LINE_CODE_1,
    mkp_pkg::LINE_CODE_2, mkp_pkg::LINE_CODE_3};

  typedef enum logic {
    STEP_TICK,
    STEP_CFG
  } step_kind_t;

  typedef struct {
    step_kind_t                 kind;
    logic [mkp_pkg::LINE_W-1:0] rows;
    logic [mkp_pkg::LINE_W-1:0] cols;
    bit                         fixed;
    logic                       exp_valid;
    logic [mkp_pkg::CODE_W-1:0] exp_code;
    logic [mkp_pkg::TICK_W-1:0] ticks;
  } dir_step_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_wr_en;
  logic [mkp_pkg::TICK_W-1:0] cfg_wr_data;

  mkp_scan_if scan_if ();
  mkp_key_if  key_if ();

  matrix_keypad_long_press_scanner uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .scan_in     (scan_if),
    .key_out     (key_if)
  );

  // Scanner state as the testbench sees it.
  mkp_pkg::phase_t            scan_ph    = mkp_pkg::PH_IDLE;
  logic [mkp_pkg::TICK_W-1:0] held_ticks = '0;
  logic [mkp_pkg::KEY_W-1:0]  held_key   = '0;
  logic [mkp_pkg::TICK_W-1:0] long_ticks = mkp_pkg::LONG_TICKS_RESET;

  mkp_pkg::result_t pending_keys [$];
  dir_step_t        dir_table [$];
  int unsigned      mismatches        = 0;
  int unsigned      sink_stall_cycles = 0;
  bit               src_idle_on       = 1'b1;
  bit               snk_idle_on       = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic bit decode_line(input logic [mkp_pkg::LINE_W-1:0] nib,
                                     output logic [1:0] idx);
    idx = '0;
    for (int k = 0; k < 4; k++) begin
      if (nib == LINE_CODES[k]) begin
        idx = 2'(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic mkp_pkg::result_t advance_scanner(
      input logic [mkp_pkg::LINE_W-1:0] rows,
      input logic [mkp_pkg::LINE_W-1:0] cols);
    mkp_pkg::result_t res;
    logic             down;
    logic [1:0]       r_idx;
    logic [1:0]       c_idx;
    bit               r_ok;
    bit               c_ok;
    res  = '0;
    down = (rows != mkp_pkg::LINES_IDLE);
    case (scan_ph)
      mkp_pkg::PH_IDLE: begin
        if (down) scan_ph = mkp_pkg::PH_DEBOUNCE;
      end
      mkp_pkg::PH_DEBOUNCE: begin
        if (!down) begin
          scan_ph = mkp_pkg::PH_IDLE;
        end else begin
          r_ok = decode_line(rows, r_idx);
          c_ok = decode_line(cols, c_idx);
          if (!(r_ok && c_ok)) begin
            scan_ph = mkp_pkg::PH_IDLE;
          end else begin
            held_key = mkp_pkg::KEY_BASE + 5'(c_idx) * 5'd4 + 5'(r_idx);
            scan_ph  = mkp_pkg::PH_HELD;
          end
        end
      end
      mkp_pkg::PH_HELD: begin
        if (down) begin
          held_ticks = held_ticks + 8'd1;
          if (held_ticks >= long_ticks) begin
            held_ticks = '0;
            scan_ph    = mkp_pkg::PH_LONG_HELD;
          end
        end else begin
          held_ticks    = '0;
          res.key_valid = 1'b1;
          res.key_code  = mkp_pkg::CODE_W'(held_key);
          held_key      = '0;
          scan_ph       = mkp_pkg::PH_IDLE;
        end
      end
      default: begin
        if (!down) begin
          res.key_valid = 1'b1;
          res.key_code  = mkp_pkg::CODE_W'(held_key) + mkp_pkg::LONG_OFFSET;
          held_key      = '0;
          scan_ph       = mkp_pkg::PH_IDLE;
        end
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_key(input logic got_valid,
                           input logic [mkp_pkg::CODE_W-1:0] got_code);
    mkp_pkg::result_t exp_key;
    if (pending_keys.size() == 0) begin
      report_mismatch($sformatf("result item with none expected (valid %0b code %0d)",
                                got_valid, got_code));
    end else begin
      exp_key = pending_keys.pop_front();
      if (got_valid !== exp_key.key_valid)
        report_mismatch($sformatf("key_valid got %0b expected %0b",
                                  got_valid, exp_key.key_valid));
      if (got_code !== exp_key.key_code)
        report_mismatch($sformatf("key_code got %0d expected %0d",
                                  got_code, exp_key.key_code));
    end
  endtask

  task automatic drive_tick(input logic [mkp_pkg::LINE_W-1:0] rows,
                            input logic [mkp_pkg::LINE_W-1:0] cols,
                            input bit fixed = 1'b0,
                            input mkp_pkg::result_t fixed_res = '0);
    int unsigned      gap;
    mkp_pkg::result_t predicted;
    if ($urandom_range(0, 63) == 0) src_idle_on = !src_idle_on;
    gap = (src_idle_on && sink_stall_cycles == 0) ? $urandom_range(0, 5) : 0;
    if (gap != 0) begin
      scan_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    scan_if.valid     <= 1'b1;
    scan_if.row_lines <= rows;
    scan_if.col_lines <= cols;
    do @(posedge clk); while (!scan_if.ready);
    predicted = advance_scanner(rows, cols);
    pending_keys.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic wait_drained();
    scan_if.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_long_ticks(input logic [mkp_pkg::TICK_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    long_ticks  = value;
  endtask

  task automatic run_phase(input logic [mkp_pkg::TICK_W-1:0] ticks, input int budget,
                           input bit pause_mid, input bit stall_sink);
    int                         done_items;
    int                         hold;
    int                         n;
    bit                         paused;
    logic [mkp_pkg::LINE_W-1:0] pat_r;
    logic [mkp_pkg::LINE_W-1:0] pat_c;
    logic [mkp_pkg::LINE_W-1:0] rows;
    done_items = 0;
    paused     = 1'b0;
    write_long_ticks(ticks);
    if (stall_sink) sink_stall_cycles = 150;
    while (done_items < budget) begin
      if (pause_mid && !paused && done_items >= budget / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      n = $urandom_range(0, 9);
      if (n <= 6) begin
        pat_r = LINE_CODES[$urandom_range(0, 3)];
        pat_c = LINE_CODES[$urandom_range(0, 3)];
        drive_tick(pat_r, pat_c);
        drive_tick(pat_r, pat_c);
        if (ticks > 32 && $urandom_range(0, 7) != 0) begin
          hold = $urandom_range(0, 12);
        end else if ($urandom_range(0, 1) == 1) begin
          hold = int'(ticks) + int'($urandom_range(0, 2)) - 1;
          if (hold < 0) hold = 0;
        end else begin
          hold = $urandom_range(0, ticks + 3);
        end
        for (int k = 0; k < hold; k++) begin
          rows = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 14)) : pat_r;
          drive_tick(rows, 4'($urandom));
        end
        drive_tick(mkp_pkg::LINES_IDLE, 4'($urandom));
        done_items += hold + 3;
      end else if (n == 7) begin
        n = $urandom_range(1, 6);
        repeat (n) drive_tick(4'($urandom), 4'($urandom));
        done_items += n;
      end else if (n == 8) begin
        drive_tick(4'($urandom_range(0, 14)), 4'($urandom));
        if ($urandom_range(0, 1) == 1) drive_tick(mkp_pkg::LINES_IDLE, 4'($urandom));
        else drive_tick(4'($urandom_range(0, 14)), 4'($urandom));
        done_items += 2;
      end else begin
        repeat ($urandom_range(1, 4)) drive_tick(mkp_pkg::LINES_IDLE, 4'($urandom));
      end
    end
  endtask

  initial begin
    int unsigned n;
    key_if.ready = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) snk_idle_on = !snk_idle_on;
      if (sink_stall_cycles != 0) begin
        key_if.ready <= 1'b0;
        repeat (sink_stall_cycles) @(posedge clk);
        sink_stall_cycles = 0;
      end
      n = snk_idle_on ? $urandom_range(0, 5) : 0;
      if (n != 0) begin
        key_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      key_if.ready <= 1'b1;
      do @(posedge clk); while (!key_if.valid);
      check_key(key_if.key_valid, key_if.key_code);
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = '0;
    scan_if.valid     = 1'b0;
    scan_if.row_lines = mkp_pkg::LINES_IDLE;
    scan_if.col_lines = mkp_pkg::LINES_IDLE;

    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'hF, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'h7, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'h7, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'hF, 1, 1'b1, 6'd4, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hE, 4'hE, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hE, 4'hE, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'hF, 1, 1'b1, 6'd19, 8'd0});
    // A bad code at decode and a release during debounce both report nothing.
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h0, 4'h0, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h0, 4'h0, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'h3, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'h3, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hB, 4'hD, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'h0, 1, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_CFG,  4'hF, 4'hF, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hD, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hD, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hD, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hD, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'hF, 1, 1'b1, 6'd30, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_CFG,  4'hF, 4'hF, 0, 1'b0, 6'd0, 8'd255});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'hE, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'h7, 4'hE, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'hF, 1, 1'b1, 6'd16, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_CFG,  4'hF, 4'hF, 0, 1'b0, 6'd0, 8'd1});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hB, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hB, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hB, 4'hB, 0, 1'b0, 6'd0, 8'd0});
    dir_table.push_back(dir_step_t'{STEP_TICK, 4'hF, 4'h5, 1, 1'b1, 6'd29, 8'd0});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == STEP_CFG) begin
        write_long_ticks(dir_table[i].ticks);
      end else begin
        drive_tick(dir_table[i].rows, dir_table[i].cols, dir_table[i].fixed,
                   mkp_pkg::result_t'{key_valid: dir_table[i].exp_valid,
                                      key_code: dir_table[i].exp_code});
      end
    end

    run_phase(8'd1, 260, 1'b0, 1'b0);
    run_phase(8'($urandom_range(2, 8)), 260, 1'b0, 1'b1);
    run_phase(8'd255, 260, 1'b0, 1'b0);
    run_phase(8'($urandom_range(1, 16)), 260, 1'b1, 1'b0);
    run_phase(8'd0, 150, 1'b0, 1'b0);
    run_phase(8'($urandom_range(4, 40)), 260, 1'b0, 1'b0);
    run_phase(mkp_pkg::LONG_TICKS_RESET, 200, 1'b0, 1'b0);

    wait_drained();
    repeat (6) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS matrix_keypad_long_press_scanner");
    end else begin
      $display("FAIL matrix_keypad_long_press_scanner");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL matrix_keypad_long_press_scanner");
    $finish;
  end

endmodule

>>> files.f
hdl/mkp_pkg.sv
hdl/mkp_scan_if.sv
hdl/mkp_key_if.sv
hdl/mkp_fsm.sv
hdl/matrix_keypad_long_press_scanner.sv
tb/sv/matrix_keypad_long_press_scanner_tb.sv
